### rtl/core/clpw_pkg.sv
// Shared types and constants of the clipped line pixel writer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package clpw_pkg;

  localparam int FIELD_W   = 16;
  localparam int CLIP_W    = 12;
  localparam int PITCH_W   = 14;
  localparam int FMT_W     = 2;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PEN_COLOR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FB_BASE      = 3'd7;

  localparam logic [FMT_W-1:0] FMT_8BIT  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_16BIT = 2'd1;
  localparam logic [FMT_W-1:0] FMT_24BIT = 2'd2;
  localparam logic [FMT_W-1:0] FMT_32BIT = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef struct packed {
    logic [CLIP_W-1:0]  clip_x_start;
    logic [CLIP_W-1:0]  clip_y_start;
    logic [CLIP_W-1:0]  clip_x_end;
    logic [CLIP_W-1:0]  clip_y_end;
    logic [PITCH_W-1:0] row_pitch;
    logic [FMT_W-1:0]   pixel_format;
    logic [DATA_W-1:0]  pen_color;
    logic [ADDR_W-1:0]  framebuffer_base;
  } cfg_regs_t;

  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
  } line_item_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  byte_address;
    logic [DATA_W-1:0]  pixel_data;
    logic [COUNT_W-1:0] byte_count;
    logic               last;
    logic               line_active;
  } pix_result_t;

endpackage

`default_nettype wire

### rtl/core/clpw_if.sv
// Channel interfaces of the clipped line pixel writer: line items in,
// pixel results out, configuration writes. Uses clpw_pkg for widths.
`default_nettype none

interface clpw_line_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [clpw_pkg::FIELD_W-1:0] start_x;
  logic signed [clpw_pkg::FIELD_W-1:0] start_y;
  logic signed [clpw_pkg::FIELD_W-1:0] end_x;
  logic signed [clpw_pkg::FIELD_W-1:0] end_y;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clpw_pix_if;
  logic                          valid;
  logic                          ready;
  logic                          write_enable;
  logic [clpw_pkg::ADDR_W-1:0]   byte_address;
  logic [clpw_pkg::DATA_W-1:0]   pixel_data;
  logic [clpw_pkg::COUNT_W-1:0]  byte_count;
  logic                          last;
  logic                          line_active;

  modport source (output valid, write_enable, byte_address, pixel_data, byte_count,
                  last, line_active, input ready);
  modport sink   (input valid, write_enable, byte_address, pixel_data, byte_count,
                  last, line_active, output ready);
endinterface

interface clpw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [clpw_pkg::CFG_IDX_W-1:0] index;
  logic [clpw_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/clpw_cfg_regs.sv
// Configuration register file of the clipped line pixel writer.
// Depends on clpw_pkg and the clpw_cfg_if interface.
`default_nettype none

module clpw_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  clpw_cfg_if.sink           cfg_wr,
  output clpw_pkg::cfg_regs_t cfg
);

  clpw_pkg::cfg_regs_t cfg_r;
  clpw_pkg::cfg_regs_t cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        clpw_pkg::REG_CLIP_X_START: cfg_nxt.clip_x_start = cfg_wr.data[clpw_pkg::CLIP_W-1:0];
        clpw_pkg::REG_CLIP_Y_START: cfg_nxt.clip_y_start = cfg_wr.data[clpw_pkg::CLIP_W-1:0];
        clpw_pkg::REG_CLIP_X_END:   cfg_nxt.clip_x_end   = cfg_wr.data[clpw_pkg::CLIP_W-1:0];
        clpw_pkg::REG_CLIP_Y_END:   cfg_nxt.clip_y_end   = cfg_wr.data[clpw_pkg::CLIP_W-1:0];
        clpw_pkg::REG_ROW_PITCH:    cfg_nxt.row_pitch    = cfg_wr.data[clpw_pkg::PITCH_W-1:0];
        clpw_pkg::REG_PIXEL_FORMAT: cfg_nxt.pixel_format = cfg_wr.data[clpw_pkg::FMT_W-1:0];
        clpw_pkg::REG_PEN_COLOR:    cfg_nxt.pen_color    = cfg_wr.data;
        clpw_pkg::REG_FB_BASE:      cfg_nxt.framebuffer_base = cfg_wr.data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/clpw_stepper.sv
// Bresenham line state and step/load datapath with clip test,
// address and pixel data generation. Depends on clpw_pkg.
`default_nettype none

module clpw_stepper #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  clpw_pkg::line_item_t item,
  input  clpw_pkg::cfg_regs_t  cfg,
  output clpw_pkg::pix_result_t result
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 2;
  localparam int EW = CW + 4;
  localparam int PX_W = clpw_pkg::CLIP_W + clpw_pkg::COUNT_W;
  localparam int PY_W = clpw_pkg::CLIP_W + clpw_pkg::PITCH_W;

  logic signed [CW-1:0] cur_x_r, cur_y_r, target_x_r, target_y_r;
  logic [DW-1:0]        tdx_r, tdy_r;
  logic signed [EW-1:0] err_r;
  logic signed [1:0]    step_x_r, step_y_r;
  logic                 x_major_r;
  logic                 busy_r;

  logic signed [CW-1:0] cur_x_nxt, cur_y_nxt;
  logic signed [EW-1:0] err_nxt;

  // load setup
  logic signed [31:0] sx32, sy32, ex32, ey32;
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic signed [CW:0]   dx, dy;
  logic [CW:0]          abs_dx, abs_dy;
  logic [DW-1:0]        ld_tdx, ld_tdy;
  logic                 ld_xmaj;
  logic signed [EW-1:0] ld_err;
  logic signed [1:0]    ld_sx, ld_sy;

  assign sx32 = 32'(item.start_x);
  assign sy32 = 32'(item.start_y);
  assign ex32 = 32'(item.end_x);
  assign ey32 = 32'(item.end_y);
  assign x1 = $signed(sx32[CW-1:0]);
  assign y1 = $signed(sy32[CW-1:0]);
  assign x2 = $signed(ex32[CW-1:0]);
  assign y2 = $signed(ey32[CW-1:0]);

  assign dx = $signed({x2[CW-1], x2}) - $signed({x1[CW-1], x1});
  assign dy = $signed({y2[CW-1], y2}) - $signed({y1[CW-1], y1});
  assign abs_dx = dx[CW] ? ((~$unsigned(dx)) + 1'b1) : $unsigned(dx);
  assign abs_dy = dy[CW] ? ((~$unsigned(dy)) + 1'b1) : $unsigned(dy);
  assign ld_tdx = {abs_dx, 1'b0};
  assign ld_tdy = {abs_dy, 1'b0};
  assign ld_xmaj = ld_tdx > ld_tdy;
  assign ld_err = ld_xmaj ? $signed(EW'(ld_tdy) - EW'(abs_dx))
                          : $signed(EW'(ld_tdx) - EW'(abs_dy));
  assign ld_sx = dx[CW] ? 2'sb11 : ((dx != '0) ? 2'sb01 : 2'sb00);
  assign ld_sy = dy[CW] ? 2'sb11 : ((dy != '0) ? 2'sb01 : 2'sb00);

  // step datapath
  logic signed [CW-1:0] nx, ny;
  logic                 err_ge;
  logic                 at_end;
  logic [DW-1:0]        minor_sub, major_add;
  logic signed [EW-1:0] err_mid;

  assign nx = cur_x_r + $signed({{(CW-2){step_x_r[1]}}, step_x_r});
  assign ny = cur_y_r + $signed({{(CW-2){step_y_r[1]}}, step_y_r});
  assign err_ge = !err_r[EW-1];
  assign at_end = x_major_r ? (cur_x_r == target_x_r) : (cur_y_r == target_y_r);
  assign minor_sub = x_major_r ? tdx_r : tdy_r;
  assign major_add = x_major_r ? tdy_r : tdx_r;
  assign err_mid = err_ge ? (err_r - $signed(EW'(minor_sub))) : err_r;

  always_comb begin
    err_nxt = err_mid + $signed(EW'(major_add));
    if (x_major_r) begin
      cur_x_nxt = nx;
      cur_y_nxt = err_ge ? ny : cur_y_r;
    end else begin
      cur_y_nxt = ny;
      cur_x_nxt = err_ge ? nx : cur_x_r;
    end
  end

  // clip, address, data
  logic                        in_window;
  logic [clpw_pkg::CLIP_W-1:0] xi, yi;
  logic [clpw_pkg::COUNT_W-1:0] bpp;
  logic [PX_W-1:0]             prod_x;
  logic [PY_W-1:0]             prod_y;
  logic [clpw_pkg::ADDR_W-1:0] addr;
  logic [clpw_pkg::DATA_W-1:0] data;

  assign in_window = !cur_x_r[CW-1] && !cur_y_r[CW-1]
                     && ($unsigned(cur_x_r) >= CW'(cfg.clip_x_start))
                     && ($unsigned(cur_x_r) <= CW'(cfg.clip_x_end))
                     && ($unsigned(cur_y_r) >= CW'(cfg.clip_y_start))
                     && ($unsigned(cur_y_r) <= CW'(cfg.clip_y_end));
  assign xi = cur_x_r[clpw_pkg::CLIP_W-1:0];
  assign yi = cur_y_r[clpw_pkg::CLIP_W-1:0];
  assign bpp = clpw_pkg::COUNT_W'(cfg.pixel_format) + 1'b1;
  assign prod_x = PX_W'(xi) * PX_W'(bpp);
  assign prod_y = PY_W'(yi) * PY_W'(cfg.row_pitch);
  assign addr = cfg.framebuffer_base + clpw_pkg::ADDR_W'(prod_x)
                + clpw_pkg::ADDR_W'(prod_y);

  always_comb begin
    case (cfg.pixel_format)
      clpw_pkg::FMT_8BIT:  data = {24'd0, cfg.pen_color[7:0]};
      clpw_pkg::FMT_16BIT: data = {16'd0, cfg.pen_color[15:0]};
      clpw_pkg::FMT_24BIT: data = {8'd0, cfg.pen_color[23:0]};
      default:             data = cfg.pen_color;
    endcase
  end

  always_comb begin
    result              = '0;
    result.byte_count   = bpp;
    if (item.mode == clpw_pkg::MODE_LOAD) begin
      result.line_active = 1'b1;
    end else if (busy_r) begin
      result.write_enable = in_window;
      result.byte_address = in_window ? addr : '0;
      result.pixel_data   = in_window ? data : '0;
      result.last         = at_end;
      result.line_active  = !at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      target_x_r <= '0;
      target_y_r <= '0;
      tdx_r      <= '0;
      tdy_r      <= '0;
      err_r      <= '0;
      step_x_r   <= '0;
      step_y_r   <= '0;
      x_major_r  <= 1'b0;
      busy_r     <= 1'b0;
    end else if (fire) begin
      if (item.mode == clpw_pkg::MODE_LOAD) begin
        cur_x_r    <= x1;
        cur_y_r    <= y1;
        target_x_r <= x2;
        target_y_r <= y2;
        tdx_r      <= ld_tdx;
        tdy_r      <= ld_tdy;
        err_r      <= ld_err;
        step_x_r   <= ld_sx;
        step_y_r   <= ld_sy;
        x_major_r  <= ld_xmaj;
        busy_r     <= 1'b1;
      end else if (busy_r) begin
        if (at_end) begin
          busy_r <= 1'b0;
        end else begin
          cur_x_r <= cur_x_nxt;
          cur_y_r <= cur_y_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/clipped_line_pixel_writer.sv
// Top level of the clipped line pixel writer: input register, line stepper,
// result register and configuration registers. Depends on clpw_pkg,
// clpw_if, clpw_cfg_regs and clpw_stepper.
//
// One result per accepted item, one item per clock sustained while the output
// is not stalled: an item sits in the input register, the stepper performs its
// load or one pixel step, and the result is held in the output register, so a
// result is offered once its item has passed the input register and then the
// output register. The per-cycle limit is the stepper datapath (error update,
// clip compare and the row times pitch product). Write configuration only while
// no item is in flight; cfg_wr.ready is always high.
`default_nettype none

module clipped_line_pixel_writer #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  clpw_line_if.sink   in_item,
  clpw_pix_if.source  out_item,
  clpw_cfg_if.sink    cfg_wr
);

  clpw_pkg::cfg_regs_t   cfg;
  clpw_pkg::line_item_t  in_item_r;
  logic                  in_valid_r;
  clpw_pkg::pix_result_t result;
  clpw_pkg::pix_result_t out_item_r;
  logic                  out_valid_r;
  logic                  advance;

  assign advance       = in_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready = !in_valid_r || advance;

  clpw_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  clpw_stepper #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_stepper (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_item.valid && in_item.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      in_item_r.mode    <= in_item.mode;
      in_item_r.start_x <= in_item.start_x;
      in_item_r.start_y <= in_item.start_y;
      in_item_r.end_x   <= in_item.end_x;
      in_item_r.end_y   <= in_item.end_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.write_enable = out_item_r.write_enable;
  assign out_item.byte_address = out_item_r.byte_address;
  assign out_item.pixel_data   = out_item_r.pixel_data;
  assign out_item.byte_count   = out_item_r.byte_count;
  assign out_item.last         = out_item_r.last;
  assign out_item.line_active  = out_item_r.line_active;

endmodule

`default_nettype wire
